FILE: rtl/srpg_pkg.sv
// Shared widths, register indexes, reset values and ramp constants of the step pulse generator.
package srpg_pkg;

   // Core sizes
   localparam int COUNT_WIDTH  = 24;
   localparam int PERIOD_WIDTH = 10;

   // Fixed field and register widths
   localparam int TICKS_W     = 24;
   localparam int STEPS_W     = 24;
   localparam int SLOPE_W     = 16;
   localparam int INTERCEPT_W = 24;
   localparam int HALF_W      = 10;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 24;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_RAMP_SLOPE      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RAMP_INTERCEPT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_HALF_PERIOD = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_HALF_PERIOD = 2'd3;

   // Register reset values
   localparam logic [SLOPE_W-1:0]     RST_RAMP_SLOPE     = 16'd461;
   localparam logic [INTERCEPT_W-1:0] RST_RAMP_INTERCEPT = 24'd946840;
   localparam logic [HALF_W-1:0]      RST_MIN_HALF       = 10'd300;
   localparam logic [HALF_W-1:0]      RST_MAX_HALF       = 10'd700;

   // Word kinds on the request side
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   // Ramp arithmetic: v / 1000 then down to a multiple of 50 equals (v / 50000) * 50.
   // v / 50000 for v < 2^24 is exact as (v * RECIP_MULT) >> RECIP_SHIFT.
   localparam int PROD_W        = SLOPE_W + COUNT_WIDTH;
   localparam int RECIP_MULT_W  = 25;
   localparam logic [RECIP_MULT_W-1:0] RECIP_MULT = 25'd21990233;
   localparam int RECIP_SHIFT   = 40;
   localparam int RECIP_PROD_W  = INTERCEPT_W + RECIP_MULT_W;
   localparam int QUOT_W        = RECIP_PROD_W - RECIP_SHIFT;
   localparam int SCALED_W      = QUOT_W + 6;
   localparam int HALF_STEP     = 50;

endpackage

FILE: rtl/stepper_ramp_pulse_generator.sv
// Stepper step pulse generator with linear speed ramp, one tick or start word per cycle unless stalled.
// A result word is registered and presented in the cycle after its request word is accepted.
// Throughput: one request word per cycle unless results stall; the result register is reloaded while it drains.
// The ramp product is registered ahead of its use: a count update is always
// followed by a low-phase expiry before the next high-phase expiry reads it.
// Reset (synchronous, active high) idles the block and loads the ramp register defaults.
module stepper_ramp_pulse_generator (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [srpg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [23:0] move_ticks (signed)
   input  logic [0:0]                        req_tuser,   // [0] action: 0 tick, 1 start
   // result side
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [srpg_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [0] step_level, [1] direction,
                                                          // [2] busy_res, [3] done_res,
                                                          // [27:4] steps_taken, [31:28] zero
   // configuration writes
   input  logic                              csr_we,
   input  logic [srpg_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [srpg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import srpg_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [SLOPE_W-1:0]     slope_ff;
   logic [SLOPE_W-1:0]     slope_in;
   logic [INTERCEPT_W-1:0] intercept_ff;
   logic [HALF_W-1:0]      min_half_ff;
   logic [HALF_W-1:0]      max_half_ff;

   // slope as it will stand after this edge, so a write reaches the product register at once
   always_comb begin
      slope_in = slope_ff;
      if (reset) begin
         slope_in = RST_RAMP_SLOPE;
      end else if (csr_we && (csr_addr == REG_RAMP_SLOPE)) begin
         slope_in = csr_wdata[SLOPE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff     <= RST_RAMP_SLOPE;
         intercept_ff <= RST_RAMP_INTERCEPT;
         min_half_ff  <= RST_MIN_HALF;
         max_half_ff  <= RST_MAX_HALF;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RAMP_SLOPE:      slope_ff     <= csr_wdata[SLOPE_W-1:0];
            REG_RAMP_INTERCEPT:  intercept_ff <= csr_wdata[INTERCEPT_W-1:0];
            REG_MIN_HALF_PERIOD: min_half_ff  <= csr_wdata[HALF_W-1:0];
            REG_MAX_HALF_PERIOD: max_half_ff  <= csr_wdata[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Move state
   // ---------------------------------------------------------------
   logic                    phase_ff,   phase_in;
   logic [COUNT_WIDTH-1:0]  count_ff,   count_in;
   logic [COUNT_WIDTH-1:0]  target_ff,  target_in;
   logic [PERIOD_WIDTH-1:0] cdown_ff,   cdown_in;
   logic [PERIOD_WIDTH-1:0] half_ff,    half_in;
   logic                    dir_ff,     dir_in;
   logic                    running_ff, running_in;
   logic                    pin_ff,     pin_in;
   logic                    done_in;

   // ---------------------------------------------------------------
   // Ramp stage 1: distance to the nearer end, times slope (runs every cycle)
   // ---------------------------------------------------------------
   logic [COUNT_WIDTH-1:0] left_dist;
   logic [COUNT_WIDTH-1:0] near_dist;
   logic [PROD_W-1:0]      prod_ff, prod_in;

   always_comb begin
      left_dist = (target_ff >= count_ff) ? (target_ff - count_ff) : (count_ff - target_ff);
      near_dist = (count_ff < left_dist) ? count_ff : left_dist;
      prod_in   = PROD_W'(slope_in) * PROD_W'(near_dist);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // ---------------------------------------------------------------
   // Ramp stage 2: (intercept - product) / 50000 * 50, clamped
   // A negative ramp value truncates to at most zero, which clamps like zero.
   // ---------------------------------------------------------------
   logic                    ramp_neg;
   logic [INTERCEPT_W-1:0]  ramp_val;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [QUOT_W-1:0]       quot;
   logic [SCALED_W-1:0]     scaled;
   logic [SCALED_W-1:0]     clamped;
   logic [PERIOD_WIDTH-1:0] next_half;

   always_comb begin
      ramp_neg   = prod_ff > PROD_W'(intercept_ff);
      ramp_val   = ramp_neg ? '0 : INTERCEPT_W'(PROD_W'(intercept_ff) - prod_ff);
      recip_prod = RECIP_PROD_W'(ramp_val) * RECIP_PROD_W'(RECIP_MULT);
      quot       = recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
      scaled     = SCALED_W'(quot) * SCALED_W'(HALF_STEP);
      clamped    = scaled;
      // low bound first, then high bound: max wins when the bounds cross
      if (clamped < SCALED_W'(min_half_ff)) begin
         clamped = SCALED_W'(min_half_ff);
      end
      if (clamped > SCALED_W'(max_half_ff)) begin
         clamped = SCALED_W'(max_half_ff);
      end
      next_half = PERIOD_WIDTH'(clamped);
   end

   // ---------------------------------------------------------------
   // Word handling
   // ---------------------------------------------------------------
   logic                   req_accept;
   logic                   ticks_neg;
   logic [TICKS_W-1:0]     ticks_mag;

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      ticks_neg  = req_tdata[TICKS_W-1];
      ticks_mag  = ticks_neg ? (TICKS_W'(0) - req_tdata) : req_tdata;

      phase_in   = phase_ff;
      count_in   = count_ff;
      target_in  = target_ff;
      cdown_in   = cdown_ff;
      half_in    = half_ff;
      dir_in     = dir_ff;
      running_in = running_ff;
      pin_in     = pin_ff;
      done_in    = 1'b0;

      if (req_tuser[0] == ACTION_START) begin
         // new move replaces any running one; pin keeps its level
         phase_in   = 1'b0;
         count_in   = '0;
         target_in  = COUNT_WIDTH'(ticks_mag);
         half_in    = PERIOD_WIDTH'(1);
         cdown_in   = PERIOD_WIDTH'(1);
         dir_in     = !ticks_neg && (req_tdata != '0);
         running_in = 1'b1;
      end else if (running_ff) begin
         if (cdown_ff > PERIOD_WIDTH'(1)) begin
            cdown_in = cdown_ff - PERIOD_WIDTH'(1);
         end else begin
            // timer expiry (a zero countdown expires like one)
            pin_in   = phase_ff;
            cdown_in = half_ff;
            if (phase_ff) begin
               half_in  = next_half;
               cdown_in = next_half;
               count_in = count_ff + COUNT_WIDTH'(1);
            end else if (count_ff == target_ff) begin
               done_in    = 1'b1;
               running_in = 1'b0;
            end
            phase_in = !phase_ff;
         end
      end

      rsp_data_in = {4'b0000, STEPS_W'(count_in), done_in, running_in, dir_in, pin_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         count_ff   <= '0;
         target_ff  <= '0;
         cdown_ff   <= '0;
         half_ff    <= '0;
         dir_ff     <= 1'b0;
         running_ff <= 1'b0;
         pin_ff     <= 1'b0;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         target_ff  <= target_in;
         cdown_ff   <= cdown_in;
         half_ff    <= half_in;
         dir_ff     <= dir_in;
         running_ff <= running_in;
         pin_ff     <= pin_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sim/testbench.sv
// Self-checking bench for the stepper ramp pulse generator: predicted pin, dir, busy, done and count words.
`timescale 1ns / 1ps

module testbench;
   import srpg_pkg::*;

   // Run guard, in clock cycles
   localparam int LIMIT = 400000;
   localparam int HOLD_CYCLES = 64;    // long result-side stall, fills the block
   localparam int HOLD_AT = 200;       // request words sent before that stall starts
   localparam int SWAP_AT = 520;       // idling mix changes after this many words
   localparam int CALM_AT = 1040;      // no idling from here on

   // One request word as it sits in the send queue
   typedef struct {
      logic                action;
      logic [TICKS_W-1:0]  ticks;
   } pulse_word_type;

   // Pulse generator state as the block keeps it, plus the done flag of the last word
   typedef struct {
      logic                   phase_hi;
      logic [COUNT_WIDTH-1:0] count;
      logic [COUNT_WIDTH-1:0] target;
      logic [PERIOD_WIDTH-1:0] countdown;
      logic [PERIOD_WIDTH-1:0] half;
      logic                   dir;
      logic                   running;
      logic                   pin;
      logic                   done;
   } gen_state_type;

   typedef struct {
      logic [SLOPE_W-1:0]     slope;
      logic [INTERCEPT_W-1:0] intercept;
      logic [HALF_W-1:0]      lo;
      logic [HALF_W-1:0]      hi;
   } tuning_type;

   // Result word we expect, stamped with the cycle its request word went in
   typedef struct {
      logic               pin;
      logic               dir;
      logic               busy;
      logic               done;
      logic [STEPS_W-1:0] steps;
      int                 accepted_at;
   } pulse_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [23:0] move_ticks (signed)
   logic [0:0]            req_tuser = '0;    // [0] action: tick or start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [0] pin, [1] dir, [2] busy, [3] done,
                                             // [27:4] steps_taken
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   stepper_ramp_pulse_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pulse_word_type pending[$];      // words waiting for the driver
   pulse_out_type  due_outputs[$];  // predicted results not yet seen
   gen_state_type  live;            // predictor state, advanced on accepted words
   gen_state_type  plan;            // generator's look-ahead copy, advanced on queued words
   tuning_type     tune;            // ramp registers as last written

   int cycles = 0;
   int words_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int planned = 0;              // queued words that the block acts on
   int phases = 0;
   int hold_left = 0;
   bit hold_used = 1'b0;
   int send_idle_pct;
   int recv_idle_pct;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idling mix follows progress: sender light / receiver heavy, swapped, then none
   always_comb begin
      send_idle_pct = (words_sent < SWAP_AT) ? 22 : (words_sent < CALM_AT) ? 55 : 0;
      recv_idle_pct = (words_sent < SWAP_AT) ? 55 : (words_sent < CALM_AT) ? 22 : 0;
   end

   // Next state of the pulse generator for one word
   function automatic gen_state_type pulse_advance(gen_state_type s, tuning_type t,
                                                   logic action, logic [TICKS_W-1:0] ticks);
      gen_state_type n;
      logic [COUNT_WIDTH-1:0] remaining;
      logic [COUNT_WIDTH-1:0] near_gap;
      longint v, ic, sl, dd, lo, hi;
      n = s;
      n.done = 1'b0;
      if (action == ACTION_START) begin
         // pin keeps its level; first expiry one tick later
         n.phase_hi = 1'b0;
         n.count = '0;
         n.target = ticks[TICKS_W-1] ? (~ticks + 1'b1) : ticks;
         n.half = 1;
         n.countdown = 1;
         n.dir = !ticks[TICKS_W-1] && (ticks != '0);
         n.running = 1'b1;
      end else if (s.running) begin
         // a countdown of zero expires like a countdown of one
         if (s.countdown > 1) begin
            n.countdown = s.countdown - 1'b1;
         end else begin
            n.pin = s.phase_hi;
            if (s.phase_hi) begin
               // ramp on distance to the nearer end of the move
               remaining = (s.target >= s.count) ? s.target - s.count : s.count - s.target;
               near_gap = (s.count < remaining) ? s.count : remaining;
               ic = t.intercept;
               sl = t.slope;
               dd = near_gap;
               lo = t.lo;
               hi = t.hi;
               v = ic - sl * dd;
               v = v / 1000;          // toward zero, negatives included
               v = (v / 50) * 50;
               if (v < lo) v = lo;    // low clamp first, so the max wins if lo > hi
               if (v > hi) v = hi;
               n.half = v[PERIOD_WIDTH-1:0];
               n.count = s.count + 1'b1;
            end else if (s.count == s.target) begin
               n.done = 1'b1;
               n.running = 1'b0;
            end
            n.phase_hi = !s.phase_hi;
            n.countdown = n.half;
         end
      end
      return n;
   endfunction

   // Driver: holds a word until taken, predicts its result on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            live = pulse_advance(live, tune, req_tuser[0], req_tdata[TICKS_W-1:0]);
            due_outputs.push_back('{live.pin, live.dir, live.running, live.done, live.count,
                                    cycles});
            words_sent <= words_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser[0] <= pending[0].action;
               req_tdata <= pending[0].ticks;
               void'(pending.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result word against the oldest prediction, drives tready
   always @(posedge clock) begin
      pulse_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            // a prediction made at this very edge is not yet due
            if (due_outputs.size() == 0 || due_outputs[0].accepted_at >= cycles) begin
               $error("result word with no request pending: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = due_outputs.pop_front();
               if (rsp_tdata[0] !== want.pin) begin
                  $error("step_level: expected %0d, got %0d", want.pin, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[1] !== want.dir) begin
                  $error("direction: expected %0d, got %0d", want.dir, rsp_tdata[1]);
                  mismatches++;
               end
               if (rsp_tdata[2] !== want.busy) begin
                  $error("busy_res: expected %0d, got %0d", want.busy, rsp_tdata[2]);
                  mismatches++;
               end
               if (rsp_tdata[3] !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_tdata[3]);
                  mismatches++;
               end
               if (rsp_tdata[4 +: STEPS_W] !== want.steps) begin
                  $error("steps_taken: expected %0d, got %0d", want.steps,
                         rsp_tdata[4 +: STEPS_W]);
                  mismatches++;
               end
            end
         end
         // one long stall early on, while the sender keeps offering words
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_used && words_sent >= HOLD_AT) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_word(input logic action, input logic [TICKS_W-1:0] ticks);
      pulse_word_type w;
      w.action = action;
      w.ticks = ticks;
      // ticks while idle are ignored by the block; don't count them
      if (action == ACTION_START || plan.running) planned++;
      pending.push_back(w);
      plan = pulse_advance(plan, tune, action, ticks);
   endtask

   // Start word, then ticks until the move ends or the cap cuts it short
   task automatic queue_move(input logic [TICKS_W-1:0] ticks, input int cap);
      int k;
      k = 0;
      queue_word(ACTION_START, ticks);
      while (plan.running && k < cap) begin
         queue_word(ACTION_TICK, TICKS_W'($urandom));
         k++;
      end
   endtask

   // Sender waits until every predicted result is back
   task automatic drain();
      do @(negedge clock); while (pending.size() != 0 || req_tvalid || due_outputs.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Zero-length move parks the block idle before the next register writes
   task automatic finish_phase();
      queue_move('0, 2);
      drain();
      phases++;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_RAMP_SLOPE:      tune.slope = val[SLOPE_W-1:0];
         REG_RAMP_INTERCEPT:  tune.intercept = val[INTERCEPT_W-1:0];
         REG_MIN_HALF_PERIOD: tune.lo = val[HALF_W-1:0];
         REG_MAX_HALF_PERIOD: tune.hi = val[HALF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_tuning(input logic [SLOPE_W-1:0] slope,
                             input logic [INTERCEPT_W-1:0] intercept,
                             input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
      write_reg(REG_RAMP_SLOPE, CSR_DATA_W'(slope));
      write_reg(REG_RAMP_INTERCEPT, CSR_DATA_W'(intercept));
      write_reg(REG_MIN_HALF_PERIOD, CSR_DATA_W'(lo));
      write_reg(REG_MAX_HALF_PERIOD, CSR_DATA_W'(hi));
   endtask

   // Mostly well-formed moves of random size and sign; some cut short by a new
   // start, some with a full-range count, some stray ticks while idle
   task automatic run_phase(input int budget, input int max_mag);
      int stop;
      int mag;
      int cap;
      logic [TICKS_W-1:0] ticks;
      stop = planned + budget;
      @(negedge clock);
      while (planned < stop) begin
         if ($urandom_range(99) < 8) begin
            queue_word(ACTION_TICK, TICKS_W'($urandom));
         end else begin
            if ($urandom_range(9) == 0) begin
               ticks = TICKS_W'($urandom);
            end else begin
               mag = $urandom_range(max_mag);
               ticks = ($urandom_range(1) == 1) ? TICKS_W'(-mag) : TICKS_W'(mag);
            end
            cap = ($urandom_range(99) < 15) ? $urandom_range(1, 12) : 400;
            // the last move of a phase stops at the word budget
            if (cap > stop - planned) cap = stop - planned;
            queue_move(ticks, cap);
         end
      end
      finish_phase();
   endtask

   initial begin
      tune.slope = RST_RAMP_SLOPE;
      tune.intercept = RST_RAMP_INTERCEPT;
      tune.lo = RST_MIN_HALF;
      tune.hi = RST_MAX_HALF;
      live = '{default: '0};
      plan = '{default: '0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset tuning: one full step with the 700 us half period
      @(negedge clock);
      queue_word(ACTION_TICK, '1);
      queue_move(TICKS_W'(1), 800);
      finish_phase();

      // Directed: one-tick half periods, so each step is two ticks
      set_tuning(SLOPE_W'(1000), INTERCEPT_W'(5000), HALF_W'(1), HALF_W'(1));
      @(negedge clock);
      queue_word(ACTION_TICK, '0);                 // idle tick, nothing moves
      queue_move('0, 4);                           // zero count: done on first expiry
      queue_move(TICKS_W'(3), 20);
      queue_move(TICKS_W'(-2), 20);                // reverse direction
      queue_move(TICKS_W'(5), 3);                  // dropped by the next start
      queue_move(24'h7FFFFF, 2);                   // largest forward count
      queue_move(24'h800000, 2);                   // most negative count
      finish_phase();

      // Random phases, each with its own register setting
      set_tuning('0, '0, HALF_W'(1), HALF_W'(1));
      run_phase(120, 12);
      set_tuning('1, '1, '0, '0);                  // zero half period
      run_phase(120, 12);
      set_tuning(SLOPE_W'(10000), INTERCEPT_W'(60000), HALF_W'(2), '1);  // ramp goes negative
      run_phase(300, 6);
      set_tuning(SLOPE_W'($urandom), INTERCEPT_W'($urandom), HALF_W'(900), HALF_W'(3));
      run_phase(150, 10);                          // min above max
      set_tuning(SLOPE_W'($urandom), INTERCEPT_W'($urandom_range(0, 400000)),
                 HALF_W'($urandom_range(0, 6)), HALF_W'($urandom_range(1, 6)));
      run_phase(150, 20);

      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d request words over %0d register settings, %0d results checked",
               words_sent, phases, results_seen);
      if (mismatches == 0 && due_outputs.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
